// File: hw/rtl/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types and constants of the SHA-256 byte stream hasher: round
// constants, initial chain value, padding constants and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef logic [31:0] t_word;

    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam int unsigned COUNT_W = 61;

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic absorb;      // shift input byte into block window
        logic finish;      // capture bit length, arm padding
        logic pad;         // shift one padding byte
        logic comp_start;  // load working vars from chain
        logic round;       // one compression round
        logic comp_add;    // chain += working vars
        logic out_push;    // load next digest word into output register
    } t_cmd;

    typedef struct packed {
        logic pos_last;    // byte position 63
        logic tail;        // current padded block carries the length
        logic round_last;  // round 63
        logic oidx_last;   // digest word 7
        logic out_free;    // output register can take a beat
    } t_sts;

endpackage

// File: hw/rtl/sbsh_ctrl.sv
// ----------------------------------------------------------------------------
// sbsh_ctrl
// Sequencer: absorb, padding, compression rounds, chain update and digest
// readout.
// ----------------------------------------------------------------------------
module sbsh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_kind,
    input  sbsh_pkg::t_sts i_sts,
    output logic           o_stall,
    output sbsh_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_ADD,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    t_state r_after, n_after;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_after = r_after;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_kind == sbsh_pkg::KIND_FINISH) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_PAD;
                    end else begin
                        o_cmd.absorb = 1'b1;
                        if (i_sts.pos_last) begin
                            o_cmd.comp_start = 1'b1;
                            n_after          = S_IDLE;
                            n_state          = S_COMP;
                        end
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                if (i_sts.pos_last) begin
                    o_cmd.comp_start = 1'b1;
                    n_after          = i_sts.tail ? S_OUT : S_PAD;
                    n_state          = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.comp_add = 1'b1;
                n_state        = r_after;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_push = 1'b1;
                    if (i_sts.oidx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// File: hw/rtl/sbsh_dp.sv
// ----------------------------------------------------------------------------
// sbsh_dp
// Datapath: 16-word block window doubling as message schedule, byte count,
// length field, working variables, chain words and digest output register.
// ----------------------------------------------------------------------------
module sbsh_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sbsh_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_data_byte,
    input  logic           i_stall,
    output sbsh_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word
);

    function automatic sbsh_pkg::t_word rotr(input sbsh_pkg::t_word v, input int unsigned s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    sbsh_pkg::t_word r_win   [16];
    sbsh_pkg::t_word r_v     [8];
    sbsh_pkg::t_word r_chain [8];
    logic [sbsh_pkg::COUNT_W-1:0] r_count;
    logic [63:0]      r_len;
    logic             r_first;
    logic             r_tail;
    logic [5:0]       r_round;
    logic [2:0]       r_oidx;
    logic             r_ovalid;
    sbsh_pkg::t_word  r_oword;
    logic [2:0]       r_oindex;
    logic             r_olast;

    logic [5:0]       pos;
    logic [7:0]       pad_byte;
    logic [7:0]       in_byte;
    logic             len_zone;
    sbsh_pkg::t_word  w_new;
    sbsh_pkg::t_word  t1;
    sbsh_pkg::t_word  t2;
    sbsh_pkg::t_word  big0;
    sbsh_pkg::t_word  big1;
    sbsh_pkg::t_word  ch;
    sbsh_pkg::t_word  maj;
    sbsh_pkg::t_word  sig0;
    sbsh_pkg::t_word  sig1;

    assign pos      = r_count[5:0];
    assign len_zone = r_tail && (pos >= sbsh_pkg::LEN_POS);

    always_comb begin
        if (r_first) begin
            pad_byte = sbsh_pkg::PAD_BYTE;
        end else if (len_zone) begin
            pad_byte = r_len[63:56];
        end else begin
            pad_byte = 8'h00;
        end
        in_byte = i_cmd.absorb ? i_data_byte : pad_byte;
    end

    always_comb begin
        sig0  = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        sig1  = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        w_new = sig1 + r_win[9] + sig0 + r_win[0];
        big1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + big1 + ch + sbsh_pkg::K_ROUND[r_round] + r_win[0];
        big0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = big0 + maj;
    end

    // block window and schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb || i_cmd.pad) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], in_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= w_new;
        end
    end

    // working variables, rounds, padding flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_v     <= r_chain;
            r_round <= '0;
        end else if (i_cmd.round) begin
            r_v[7]  <= r_v[6];
            r_v[6]  <= r_v[5];
            r_v[5]  <= r_v[4];
            r_v[4]  <= r_v[3] + t1;
            r_v[3]  <= r_v[2];
            r_v[2]  <= r_v[1];
            r_v[1]  <= r_v[0];
            r_v[0]  <= t1 + t2;
            r_round <= r_round + 6'd1;
        end
        if (i_cmd.finish) begin
            r_len   <= {r_count, 3'b000};
            r_first <= 1'b1;
            r_tail  <= (pos < sbsh_pkg::LEN_POS);
        end else if (i_cmd.pad) begin
            r_first <= 1'b0;
            if (len_zone) begin
                r_len <= {r_len[55:0], 8'h00};
            end
            if (pos == 6'd63) begin
                r_tail <= 1'b1;
            end
        end
    end

    // chain, byte count, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain  <= sbsh_pkg::IV;
            r_count  <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.absorb || i_cmd.pad) begin
                r_count <= r_count + {{(sbsh_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
            if (i_cmd.comp_add) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
            if (i_cmd.out_push) begin
                r_ovalid <= 1'b1;
                r_oidx   <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_chain <= sbsh_pkg::IV;
                    r_count <= '0;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_push) begin
            r_oword  <= r_chain[r_oidx];
            r_oindex <= r_oidx;
            r_olast  <= (r_oidx == 3'd7);
        end
    end

    assign o_sts.pos_last   = (pos == 6'd63);
    assign o_sts.tail       = r_tail;
    assign o_sts.round_last = (r_round == 6'd63);
    assign o_sts.oidx_last  = (r_oidx == 3'd7);
    assign o_sts.out_free   = !r_ovalid || !i_stall;

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oindex;
    assign o_last_word   = r_olast;

endmodule

// File: hw/rtl/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream: absorb beats append bytes, a finish beat pads
// the message and returns the eight digest words, then rearms for the next
// message.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  input   | in  | i_valid / o_stall  | i_kind, i_data_byte
//  output  | out | o_valid / i_stall  | o_digest_word, o_word_index, o_last_word
//
//  Absorb beat: one byte; the 64th byte of a block also starts compression
//  (64 rounds of the single round unit, then the chain add).
//  Finish beat: padding fills the block up to byte 63, then it is compressed;
//  when the length spills, a second padded block is compressed as well; then
//  the eight digest words go out, held back while the output is stalled.
//  Synchronous active-low reset loads the initial chain and clears the count.
//  One beat in flight; o_stall is high whenever the sequencer is busy.
module sha256_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sbsh_pkg::t_cmd cmd;
    sbsh_pkg::t_sts sts;

    sbsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    sbsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .i_stall       (i_stall),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

`ifndef SYNTHESIS
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_kind == sbsh_pkg::KIND_FINISH) |=> o_stall)
        else $error("finish beat did not start padding");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_push && sts.oidx_last) |=> (!o_stall && o_valid && o_last_word))
        else $error("digest readout did not return to idle");

    a_round_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.round || cmd.comp_add) |-> o_stall)
        else $error("input accepted during compression");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last flag does not match word index");
`endif

endmodule

// File: tb/sv/sha256_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Follows every accepted input beat of the hasher with its own SHA-256 state
// (chain words, block bytes, message byte count) and queues the eight digest
// beats that a finish produces. Each accepted output beat is compared field
// by field against the oldest queued digest beat.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_in_kind,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_out_word,
    input  logic [2:0]  i_out_index,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] CHAIN_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] MSG_PAD    = 8'h80;
    localparam int         LEN_OFFSET = 56;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    logic [31:0]  chain_h [8];
    logic [7:0]   msg_block [64];
    logic [60:0]  msg_bytes;
    logic [63:0]  bit_len;
    logic [5:0]   fill_pos;
    t_digest_beat digest_q [$];
    t_digest_beat beat;
    int           fail_total = 0;
    int           k;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        int          r;
        for (r = 0; r < 16; r++) begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (r = 16; r < 64; r++) begin
            s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        for (r = 0; r < 8; r++) begin
            v[r] = chain_h[r];
        end
        for (r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++) begin
            chain_h[r] = chain_h[r] + v[r];
        end
    endtask

    task automatic restart_message();
        int i;
        for (i = 0; i < 8; i++) begin
            chain_h[i] = CHAIN_INIT[i];
        end
        msg_bytes = '0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                fill_pos = msg_bytes[5:0];
                if (i_in_kind == sbsh_pkg::KIND_ABSORB) begin
                    msg_block[fill_pos] = i_in_byte;
                    msg_bytes = msg_bytes + 61'd1;
                    if (msg_bytes[5:0] == 6'd0) begin
                        compress_block();
                    end
                end else begin
                    bit_len = {msg_bytes, 3'b000};
                    msg_block[fill_pos] = MSG_PAD;
                    for (k = fill_pos + 1; k < 64; k++) begin
                        msg_block[k] = 8'h00;
                    end
                    // no room for the length: pad block goes out alone
                    if (fill_pos >= LEN_OFFSET) begin
                        compress_block();
                        for (k = 0; k < LEN_OFFSET; k++) begin
                            msg_block[k] = 8'h00;
                        end
                    end
                    for (k = 0; k < 8; k++) begin
                        msg_block[LEN_OFFSET + k] = bit_len[63 - 8*k -: 8];
                    end
                    compress_block();
                    for (k = 0; k < 8; k++) begin
                        beat.word  = chain_h[k];
                        beat.index = k[2:0];
                        beat.last  = (k == 7);
                        digest_q.push_back(beat);
                    end
                    restart_message();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("digest beat with nothing expected: word %08h index %0d",
                           i_out_word, i_out_index);
                    fail_total++;
                end else begin
                    beat = digest_q.pop_front();
                    if (i_out_word !== beat.word) begin
                        $error("digest_word mismatch: expected %08h, actual %08h",
                               beat.word, i_out_word);
                        fail_total++;
                    end
                    if (i_out_index !== beat.index) begin
                        $error("word_index mismatch: expected %0d, actual %0d",
                               beat.index, i_out_index);
                        fail_total++;
                    end
                    if (i_out_last !== beat.last) begin
                        $error("last_word mismatch: expected %0b, actual %0b",
                               beat.last, i_out_last);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= digest_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the SHA-256 hasher: known vectors and empty
// messages first, then random messages including the lengths where the
// padding just fits, spills into a second block, or follows a full block.
// Both channels idle at random; one long output hold backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEM_TARGET    = 230;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    // length fits, length spills, block full before the finish
    localparam int BOUNDARY_LEN [3] = '{55, 56, 64};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_kind;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int fail_count;
    int pending_beats;
    int items_sent  = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    int rx_left     = 0;
    bit rx_stalling = 1'b0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int msg_num     = 0;

    sha256_byte_stream_hasher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    sha256_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_kind    (i_kind),
        .i_in_byte    (i_data_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_word   (o_digest_word),
        .i_out_index  (o_word_index),
        .i_out_last   (o_last_word),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, some none, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (quiet || r < 6) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    task automatic send_beat(input logic kind, input logic [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_kind      <= 1'($urandom_range(0, 1));
            i_data_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        int n;
        quiet = ($urandom_range(0, 3) == 0);
        for (n = 0; n < len; n++) begin
            send_beat(sbsh_pkg::KIND_ABSORB, 8'($urandom_range(0, 255)));
        end
        send_beat(sbsh_pkg::KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // output side
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && o_valid) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_stalling = !rx_stalling;
                    rx_left = rx_stalling ? pick_gap() : $urandom_range(1, 24);
                    if (rx_left == 0) begin
                        rx_stalling = 1'b0;
                        rx_left     = $urandom_range(1, 24);
                    end
                end
                rx_left--;
                i_stall <= rx_stalling;
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_kind      <= sbsh_pkg::KIND_ABSORB;
        i_data_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message
        send_beat(sbsh_pkg::KIND_FINISH, 8'h00);
        // "abc"
        send_beat(sbsh_pkg::KIND_ABSORB, 8'h61);
        send_beat(sbsh_pkg::KIND_ABSORB, 8'h62);
        send_beat(sbsh_pkg::KIND_ABSORB, 8'h63);
        send_beat(sbsh_pkg::KIND_FINISH, 8'h00);
        send_beat(sbsh_pkg::KIND_ABSORB, 8'h00);
        send_beat(sbsh_pkg::KIND_ABSORB, 8'hff);
        send_beat(sbsh_pkg::KIND_FINISH, 8'h00);
        // back-to-back empty messages
        send_beat(sbsh_pkg::KIND_FINISH, 8'h00);
        send_beat(sbsh_pkg::KIND_FINISH, 8'hff);
        // data byte ignored on finish
        send_beat(sbsh_pkg::KIND_ABSORB, 8'h5a);
        send_beat(sbsh_pkg::KIND_FINISH, 8'hff);

        hold_req = 1'b1;
        while (items_sent < ITEM_TARGET || msg_num < 6) begin
            if (msg_num % 2 == 1 && msg_num < 6) begin
                send_message(BOUNDARY_LEN[msg_num / 2]);
            end else begin
                send_message($urandom_range(0, 12));
            end
            msg_num++;
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sbsh_pkg.sv
hw/rtl/sbsh_ctrl.sv
hw/rtl/sbsh_dp.sv
hw/rtl/sha256_byte_stream_hasher_top.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_top.sv
